// ===== hdl/dsa_pkg.sv =====
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared types and constants of the depth shift anaglyph pixel core: request
// and result layouts, configuration indexes, reset values and the command
// and status groups between sequencer and datapath.
// ----------------------------------------------------------------------------
package dsa_pkg;

	// channel and field widths
	localparam int CHAN_W        = 8;
	localparam int DEPTH_W       = 8;
	localparam int GAIN_W        = 9;
	localparam int CURVE_ENTRIES = 256;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int ROW_W      = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISPLACE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_MODE       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HAS_ALPHA = 2'd3;

	// register reset values
	localparam logic [CHAN_W-1:0] RST_MAX_DISPLACE     = 8'd50;
	localparam logic [ROW_W-1:0]  RST_ROW_WIDTH        = 13'd1024;
	localparam logic              RST_SHIFT_MODE       = 1'b1;
	localparam logic              RST_SOURCE_HAS_ALPHA = 1'b0;

	// request kinds
	localparam logic CMD_CURVE = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	// shift modes
	localparam logic MODE_GREEN = 1'b0;
	localparam logic MODE_RED   = 1'b1;

	localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hff;
	localparam logic [CHAN_W-1:0] DISP_MAX     = 8'd255;

	// default sizes
	localparam int SHIFT_WINDOW_DEF  = 256;
	localparam int MAX_ROW_WIDTH_DEF = 4096;

	typedef struct packed {
		logic              cmd;
		logic [DEPTH_W-1:0] depth;
		logic [GAIN_W-1:0]  curve_gain;
		logic [CHAN_W-1:0]  in_red;
		logic [CHAN_W-1:0]  in_green;
		logic [CHAN_W-1:0]  in_blue;
		logic [CHAN_W-1:0]  in_alpha;
	} src_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
		logic [CHAN_W-1:0] out_alpha;
		logic              shifted_filled;
		logic              end_of_row;
	} dst_item_t;

	// sequencer to datapath
	typedef struct packed {
		logic load_in;
		logic curve_we;
		logic mul_en;
		logic div_en;
		logic scale_en;
		logic pend_wr;
		logic pend_rd;
		logic load_out;
	} dp_cmd_t;

	// datapath to sequencer
	typedef struct packed {
		logic src_is_pixel;
	} dp_sts_t;

endpackage

// ===== hdl/dsa_ram.sv =====
// ----------------------------------------------------------------------------
// dsa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/dsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// dsa_ctrl
// Sequencer of the pixel core: takes requests, steps the datapath through
// multiply, divide, curve lookup, scale, store write, store read and emit,
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module dsa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             src_valid,
	output logic             src_stall,
	output logic             dst_valid,
	input  logic             dst_stall,
	input  dsa_pkg::dp_sts_t sts,
	output dsa_pkg::dp_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_SCALE = 3'd3;
	localparam logic [2:0] ST_WRITE = 3'd4;
	localparam logic [2:0] ST_READ  = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       dst_valid_q;
	logic       src_accept;
	logic       emit_go;

	assign src_stall  = (state_q != ST_IDLE);
	assign src_accept = src_valid && !src_stall;
	assign emit_go    = (state_q == ST_EMIT) && (!dst_valid_q || !dst_stall);

	// datapath commands
	always_comb begin
		cmd          = '0;
		cmd.load_in  = src_accept && (sts.src_is_pixel == dsa_pkg::CMD_PIXEL);
		cmd.curve_we = src_accept && (sts.src_is_pixel == dsa_pkg::CMD_CURVE);
		cmd.mul_en   = (state_q == ST_MUL);
		cmd.div_en   = (state_q == ST_DIV);
		cmd.scale_en = (state_q == ST_SCALE);
		cmd.pend_wr  = (state_q == ST_WRITE);
		cmd.pend_rd  = (state_q == ST_READ);
		cmd.load_out = emit_go;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load_in) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:   state_d = ST_DIV;
			ST_DIV:   state_d = ST_SCALE;
			ST_SCALE: state_d = ST_WRITE;
			ST_WRITE: state_d = ST_READ;
			ST_READ:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit_go) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid_q <= 1'b0;
		end else if (emit_go) begin
			dst_valid_q <= 1'b1;
		end else if (!dst_stall) begin
			dst_valid_q <= 1'b0;
		end
	end

	assign dst_valid = dst_valid_q;

endmodule

// ===== hdl/dsa_dp.sv =====
// ----------------------------------------------------------------------------
// dsa_dp
// Datapath of the pixel core: configuration registers, displacement
// arithmetic, gain curve memory, pending store with occupancy bits, column
// counter and result register.
// ----------------------------------------------------------------------------
module dsa_dp #(
	parameter int SHIFT_WINDOW  = dsa_pkg::SHIFT_WINDOW_DEF,
	parameter int MAX_ROW_WIDTH = dsa_pkg::MAX_ROW_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [dsa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dsa_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  dsa_pkg::src_item_t               src_data,
	output dsa_pkg::dst_item_t               dst_data,
	input  dsa_pkg::dp_cmd_t                 cmd,
	output dsa_pkg::dp_sts_t                 sts
);

	localparam int CW = $clog2(MAX_ROW_WIDTH);
	localparam int SW = $clog2(SHIFT_WINDOW);
	localparam int EW = $clog2(MAX_ROW_WIDTH + 1);
	localparam int A1 = (CW > SW) ? CW : SW;
	localparam int A2 = (A1 > EW) ? A1 : EW;
	localparam int A3 = (A2 > dsa_pkg::ROW_W) ? A2 : dsa_pkg::ROW_W;
	localparam int AW = A3 + 1;
	localparam int CA = $clog2(dsa_pkg::CURVE_ENTRIES);

	// configuration registers
	logic [dsa_pkg::CHAN_W-1:0] max_displace_q;
	logic [dsa_pkg::ROW_W-1:0]  row_width_q;
	logic                       shift_mode_q;
	logic                       source_has_alpha_q;

	// pipeline and state
	dsa_pkg::src_item_t          in_q;
	logic [15:0]                 prod_s1;
	logic [dsa_pkg::CHAN_W-1:0]  base_s2;
	logic                        cvld_s2;
	logic [16:0]                 scale_s3;
	logic                        filled_q;
	logic [CW-1:0]               column_q;
	logic [dsa_pkg::CURVE_ENTRIES-1:0] cvld_q;
	logic [SHIFT_WINDOW-1:0]     pvld_q;
	dsa_pkg::dst_item_t          out_q;

	// combinational values
	logic [16:0]                 div_sum;
	logic [dsa_pkg::CHAN_W-1:0]  base_c;
	logic [dsa_pkg::GAIN_W-1:0]  curve_rd;
	logic [dsa_pkg::GAIN_W-1:0]  gain_c;
	logic [dsa_pkg::CHAN_W-1:0]  disp_c;
	logic [AW-1:0]               col_a;
	logic [AW-1:0]               target_a;
	logic [AW-1:0]               rw_a;
	logic [AW-1:0]               width_a;
	logic [AW-1:0]               col_p1;
	logic                        in_range;
	logic                        eor_c;
	logic [SW-1:0]               wr_slot;
	logic [SW-1:0]               rd_slot;
	logic [dsa_pkg::CHAN_W-1:0]  shift_val;
	logic [dsa_pkg::CHAN_W-1:0]  pend_rd;
	logic [dsa_pkg::CHAN_W-1:0]  landed;

	assign sts.src_is_pixel = src_data.cmd;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_displace_q     <= dsa_pkg::RST_MAX_DISPLACE;
			row_width_q        <= dsa_pkg::RST_ROW_WIDTH;
			shift_mode_q       <= dsa_pkg::RST_SHIFT_MODE;
			source_has_alpha_q <= dsa_pkg::RST_SOURCE_HAS_ALPHA;
		end else if (cfg_we) begin
			case (cfg_index)
				dsa_pkg::CFG_MAX_DISPLACE:
					max_displace_q <= cfg_data[dsa_pkg::CHAN_W-1:0];
				dsa_pkg::CFG_ROW_WIDTH:
					row_width_q <= cfg_data[dsa_pkg::ROW_W-1:0];
				dsa_pkg::CFG_SHIFT_MODE:
					shift_mode_q <= cfg_data[0];
				dsa_pkg::CFG_SOURCE_HAS_ALPHA:
					source_has_alpha_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q <= src_data;
		end
	end

	// depth times largest shift
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1 <= 16'(max_displace_q) * 16'(in_q.depth);
		end
	end

	// divide by 255 through reciprocal with correction
	assign div_sum = {1'b0, prod_s1} + {9'd0, prod_s1[15:8]} + 17'd1;
	assign base_c  = div_sum[15:8];

	always_ff @(posedge clk) begin
		if (cmd.div_en) begin
			base_s2 <= base_c;
			cvld_s2 <= cvld_q[base_c];
		end
	end

	// gain curve: unwritten entries read as the linear ramp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cvld_q <= '0;
		end else if (cmd.curve_we) begin
			cvld_q[src_data.depth[CA-1:0]] <= 1'b1;
		end
	end

	dsa_ram #(
		.WIDTH (dsa_pkg::GAIN_W),
		.DEPTH (dsa_pkg::CURVE_ENTRIES)
	) u_curve_ram (
		.clk   (clk),
		.we    (cmd.curve_we),
		.waddr (src_data.depth[CA-1:0]),
		.wdata (src_data.curve_gain),
		.re    (cmd.div_en),
		.raddr (base_c[CA-1:0]),
		.rdata (curve_rd)
	);

	assign gain_c = cvld_s2 ? curve_rd : {1'b0, base_s2};

	// scale by curve gain
	always_ff @(posedge clk) begin
		if (cmd.scale_en) begin
			scale_s3 <= 17'(base_s2) * 17'(gain_c);
		end
	end

	// saturated displacement and shift target
	assign disp_c   = scale_s3[16] ? dsa_pkg::DISP_MAX : scale_s3[15:8];
	assign col_a    = AW'(column_q);
	assign target_a = col_a + AW'(disp_c);
	assign rw_a     = AW'(row_width_q);

	// effective row width
	always_comb begin
		width_a = rw_a;
		if (rw_a == '0) begin
			width_a = AW'(1);
		end else if (rw_a > AW'(MAX_ROW_WIDTH)) begin
			width_a = AW'(MAX_ROW_WIDTH);
		end
	end

	assign in_range  = (target_a < width_a);
	assign wr_slot   = target_a[SW-1:0];
	assign rd_slot   = col_a[SW-1:0];
	assign shift_val = (shift_mode_q == dsa_pkg::MODE_RED) ? in_q.in_red : in_q.in_green;

	dsa_ram #(
		.WIDTH (dsa_pkg::CHAN_W),
		.DEPTH (SHIFT_WINDOW)
	) u_pend_ram (
		.clk   (clk),
		.we    (cmd.pend_wr && in_range),
		.waddr (wr_slot),
		.wdata (shift_val),
		.re    (cmd.pend_rd),
		.raddr (rd_slot),
		.rdata (pend_rd)
	);

	// occupancy bits: set on landing, cleared on read and at row end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvld_q <= '0;
		end else if (cmd.load_out && eor_c) begin
			pvld_q <= '0;
		end else if (cmd.pend_wr && in_range) begin
			pvld_q[wr_slot] <= 1'b1;
		end else if (cmd.pend_rd) begin
			pvld_q[rd_slot] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pend_rd) begin
			filled_q <= pvld_q[rd_slot];
		end
	end

	// row position
	assign col_p1 = col_a + AW'(1);
	assign eor_c  = (col_p1 >= width_a);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
		end else if (cmd.load_out) begin
			column_q <= eor_c ? '0 : col_p1[CW-1:0];
		end
	end

	// result register
	assign landed = filled_q ? pend_rd : '0;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (shift_mode_q == dsa_pkg::MODE_RED) begin
				out_q.out_red   <= landed;
				out_q.out_green <= in_q.in_green;
			end else begin
				out_q.out_red   <= in_q.in_red;
				out_q.out_green <= landed;
			end
			out_q.out_blue       <= in_q.in_blue;
			out_q.out_alpha      <= source_has_alpha_q ? in_q.in_alpha : dsa_pkg::ALPHA_OPAQUE;
			out_q.shifted_filled <= filled_q;
			out_q.end_of_row     <= eor_c;
		end
	end

	assign dst_data = out_q;

endmodule

// ===== hdl/depth_shift_anaglyph_pixel_core.sv =====
// ----------------------------------------------------------------------------
// depth_shift_anaglyph_pixel_core
// Depth driven anaglyph channel shifter: moves the red or green channel of
// each pixel rightward within its row by a curve-scaled displacement.
//
//   channel | signals                        | moves
//   --------+--------------------------------+------------------------------
//   src     | src_valid, src_stall, src_data | pixel or curve load request
//   dst     | dst_valid, dst_stall, dst_data | one result per pixel
//   cfg     | cfg_we, cfg_index, cfg_data    | register write
//
// a pixel holds the request side through multiply, divide by 255 with curve
// read, scale, store write, store read and emit, so the core takes no new
// request before the pixel is emitted; the result register loads at emit.
// a curve load is written in the cycle it is accepted.
// the emit step waits while the result register is full and stalled.
// after reset the curve reads as a linear ramp through per-entry valid bits;
// there is no clearing pass.
// ----------------------------------------------------------------------------
module depth_shift_anaglyph_pixel_core #(
	parameter int SHIFT_WINDOW  = dsa_pkg::SHIFT_WINDOW_DEF,
	parameter int MAX_ROW_WIDTH = dsa_pkg::MAX_ROW_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           src_valid,
	output logic                           src_stall,
	input  dsa_pkg::src_item_t             src_data,
	output logic                           dst_valid,
	input  logic                           dst_stall,
	output dsa_pkg::dst_item_t             dst_data,
	input  logic                           cfg_we,
	input  logic [dsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dsa_pkg::CFG_DATA_W-1:0] cfg_data
);

	dsa_pkg::dp_cmd_t cmd;
	dsa_pkg::dp_sts_t sts;

	// sequencer
	dsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath
	dsa_dp #(
		.SHIFT_WINDOW  (SHIFT_WINDOW),
		.MAX_ROW_WIDTH (MAX_ROW_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src_data  (src_data),
		.dst_data  (dst_data),
		.cmd       (cmd),
		.sts       (sts)
	);

`ifndef ASSERT_OFF
	// a pixel request keeps the block busy on the next cycle
	a_pixel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(src_valid && !src_stall && src_data.cmd == dsa_pkg::CMD_PIXEL) |=> src_stall)
		else $error("pixel request did not start the sequence");

	// a curve load completes in its own cycle
	a_curve_free: assert property (@(posedge clk) disable iff (!arst_n)
		(src_valid && !src_stall && src_data.cmd == dsa_pkg::CMD_CURVE) |=> !src_stall)
		else $error("curve load held the request side");

	// an emitted result shows on the output next cycle
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> dst_valid)
		else $error("emitted result not presented");

	// results are only emitted while no request is being taken
	a_emit_alone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (src_stall && !cmd.pend_wr && !cmd.curve_we))
		else $error("emit overlapped other work");
`endif

endmodule

// ===== sim/depth_shift_anaglyph_pixel_core_tb.sv =====
// ----------------------------------------------------------------------------
// depth_shift_anaglyph_pixel_core_tb
// Self-checking bench for the depth shift anaglyph core. A driver process sends
// pixel and curve load requests from a queue, and a predictor computes the
// shifted result for each pixel request it sends. A monitor process compares
// every result, field by field, against the oldest predicted pixel. The run
// starts with hand-picked rows and then covers many register settings with
// random rows. Both sides stall at random, and one long receiver hold fills
// the core.
// ----------------------------------------------------------------------------
module depth_shift_anaglyph_pixel_core_tb;
	import dsa_pkg::*;

	localparam int SETTLE_CYCLES  = 20;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SEGMENTS       = 12;
	localparam int SEGMENT_ITEMS  = 100;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  src_valid = 1'b0;
	logic                  src_stall;
	src_item_t             src_data  = '0;
	logic                  dst_valid;
	logic                  dst_stall = 1'b0;
	dst_item_t             dst_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// predictor copy of registers and state
	logic [CHAN_W-1:0] max_disp;
	logic [ROW_W-1:0]  row_w;
	logic              mode_sel;
	logic              keep_alpha;
	logic [GAIN_W-1:0] curve_gain_tbl [CURVE_ENTRIES];
	logic [CHAN_W-1:0] landing_val [SHIFT_WINDOW_DEF];
	logic              landing_ok [SHIFT_WINDOW_DEF];
	logic [11:0]       col;

	src_item_t request_fifo [$];
	dst_item_t expected_pixels [$];

	int  src_idle_max = 7;
	int  dst_idle_max = 7;
	int  gap_left     = 0;
	int  stall_left   = 0;
	int  hold_left    = 0;
	bit  hold_wanted  = 1'b0;
	bit  hold_done    = 1'b0;
	int  mismatches   = 0;
	int  results_seen = 0;
	int  quiet_cycles = 0;

	// per-segment register settings, extremes included
	int unsigned seg_width [SEGMENTS] = '{1, 2, 5, 16, 300, 37, 0, 255, 4096, 8191, 256, 1024};
	int unsigned seg_disp  [SEGMENTS] = '{255, 0, 7, 255, 50, 128, 255, 200, 255, 1, 255, 90};

	depth_shift_anaglyph_pixel_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// predicted effect of one accepted request
	task automatic predict_request(input src_item_t rq);
		int unsigned       width;
		int unsigned       base;
		int unsigned       shift;
		int unsigned       target;
		int unsigned       slot;
		logic [CHAN_W-1:0] landed;
		logic              hit;
		dst_item_t         px;
		if (rq.cmd == CMD_CURVE) begin
			curve_gain_tbl[rq.depth] = rq.curve_gain;
		end else begin
			width = (row_w == 0) ? 1 : (row_w > MAX_ROW_WIDTH_DEF) ? MAX_ROW_WIDTH_DEF : row_w;
			base  = (int'(max_disp) * int'(rq.depth)) / 255;
			shift = (base * int'(curve_gain_tbl[base])) >> 8;
			if (shift > DISP_MAX)
				shift = DISP_MAX;
			// shifted channel lands to the right, dropped past the row end
			target = int'(col) + shift;
			if (target < width) begin
				slot = target % SHIFT_WINDOW_DEF;
				landing_val[slot] = (mode_sel == MODE_RED) ? rq.in_red : rq.in_green;
				landing_ok[slot]  = 1'b1;
			end
			// current position is final now
			slot   = int'(col) % SHIFT_WINDOW_DEF;
			hit    = landing_ok[slot];
			landed = hit ? landing_val[slot] : '0;
			landing_ok[slot]  = 1'b0;
			landing_val[slot] = '0;
			px.out_red        = (mode_sel == MODE_RED) ? landed : rq.in_red;
			px.out_green      = (mode_sel == MODE_GREEN) ? landed : rq.in_green;
			px.out_blue       = rq.in_blue;
			px.out_alpha      = keep_alpha ? rq.in_alpha : ALPHA_OPAQUE;
			px.shifted_filled = hit;
			px.end_of_row     = (int'(col) + 1 >= width);
			if (px.end_of_row) begin
				col = '0;
				foreach (landing_ok[i])
					landing_ok[i] = 1'b0;
			end else begin
				col = col + 1'b1;
			end
			expected_pixels.push_back(px);
		end
	endtask

	task automatic push_pixel(input int dep, input int r, input int g, input int b, input int a);
		src_item_t rq;
		rq.cmd        = CMD_PIXEL;
		rq.depth      = DEPTH_W'(dep);
		rq.curve_gain = GAIN_W'($urandom_range(0, 511));
		rq.in_red     = CHAN_W'(r);
		rq.in_green   = CHAN_W'(g);
		rq.in_blue    = CHAN_W'(b);
		rq.in_alpha   = CHAN_W'(a);
		request_fifo.push_back(rq);
	endtask

	task automatic push_curve(input int idx, input int gain);
		src_item_t rq;
		rq.cmd        = CMD_CURVE;
		rq.depth      = DEPTH_W'(idx);
		rq.curve_gain = GAIN_W'(gain);
		rq.in_red     = CHAN_W'($urandom);
		rq.in_green   = CHAN_W'($urandom);
		rq.in_blue    = CHAN_W'($urandom);
		rq.in_alpha   = CHAN_W'($urandom);
		request_fifo.push_back(rq);
	endtask

	// register write while the core is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			CFG_MAX_DISPLACE:     max_disp   = val[CHAN_W-1:0];
			CFG_ROW_WIDTH:        row_w      = val[ROW_W-1:0];
			CFG_SHIFT_MODE:       mode_sel   = val[0];
			CFG_SOURCE_HAS_ALPHA: keep_alpha = val[0];
			default: ;
		endcase
	endtask

	// all requests sent and all results back, then let curve loads finish
	task automatic wait_drained();
		do
			@(negedge clk);
		while (request_fifo.size() != 0 || src_valid || expected_pixels.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic check_result(input dst_item_t got);
		dst_item_t want;
		results_seen++;
		if (expected_pixels.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d arrived with nothing expected: %h", results_seen, got);
		end else begin
			want = expected_pixels.pop_front();
			if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
					got.out_blue !== want.out_blue || got.out_alpha !== want.out_alpha ||
					got.shifted_filled !== want.shifted_filled ||
					got.end_of_row !== want.end_of_row) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result %0d mismatch: expected r=%0d g=%0d b=%0d a=%0d fill=%0b eor=%0b",
						results_seen, want.out_red, want.out_green, want.out_blue,
						want.out_alpha, want.shifted_filled, want.end_of_row);
					$display("            actual   r=%0d g=%0d b=%0d a=%0d fill=%0b eor=%0b",
						got.out_red, got.out_green, got.out_blue, got.out_alpha,
						got.shifted_filled, got.end_of_row);
				end
			end
		end
	endtask

	// request driver with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			src_data  <= '0;
			gap_left   = 0;
		end else begin
			if (src_valid && !src_stall) begin
				predict_request(src_data);
				gap_left = $urandom_range(0, src_idle_max);
			end
			if (src_valid && src_stall) begin
				// hold the stalled request
			end else if (gap_left > 0) begin
				gap_left--;
				src_valid <= 1'b0;
			end else if (request_fifo.size() != 0) begin
				src_data  <= request_fifo.pop_front();
				src_valid <= 1'b1;
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	// result monitor with random stalls and one long hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_stall <= 1'b0;
			stall_left = 0;
			hold_left  = 0;
		end else begin
			if (dst_valid && !dst_stall) begin
				check_result(dst_data);
				stall_left = $urandom_range(0, dst_idle_max);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			if (hold_wanted && !hold_done) begin
				hold_left = LONG_HOLD;
				hold_done = 1'b1;
			end else if (hold_left > 0) begin
				hold_left--;
			end
			dst_stall <= (stall_left > 0) || (hold_left > 0);
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (src_valid && !src_stall) || (dst_valid && !dst_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int seg;
		int k;
		max_disp   = RST_MAX_DISPLACE;
		row_w      = RST_ROW_WIDTH;
		mode_sel   = RST_SHIFT_MODE;
		keep_alpha = RST_SOURCE_HAS_ALPHA;
		col        = '0;
		foreach (curve_gain_tbl[i])
			curve_gain_tbl[i] = GAIN_W'(i);
		foreach (landing_ok[i]) begin
			landing_ok[i]  = 1'b0;
			landing_val[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// short row, full displacement, curve extremes and large gain
		write_reg(CFG_MAX_DISPLACE, 255);
		write_reg(CFG_ROW_WIDTH, 8);
		write_reg(CFG_SHIFT_MODE, MODE_RED);
		write_reg(CFG_SOURCE_HAS_ALPHA, 1);
		push_curve(255, 511);
		push_curve(128, 256);
		push_curve(0, 0);
		push_pixel(23, 255, 0, 255, 0);      // lands two to the right
		push_pixel(16, 0, 255, 0, 255);      // same target, later one wins
		push_pixel(0, 8'haa, 8'h55, 1, 2);   // no shift, overwrites again
		push_pixel(255, 3, 4, 5, 6);         // saturated shift, dropped
		push_pixel(16, 7, 8, 9, 10);
		push_pixel(128, 11, 12, 13, 14);     // past the row end
		push_pixel(16, 15, 16, 17, 18);
		push_pixel(0, 19, 20, 21, 22);       // row end
		wait_drained();

		// zero width acts as one, green mode, opaque alpha
		write_reg(CFG_MAX_DISPLACE, 0);
		write_reg(CFG_ROW_WIDTH, 0);
		write_reg(CFG_SHIFT_MODE, MODE_GREEN);
		write_reg(CFG_SOURCE_HAS_ALPHA, 0);
		push_pixel(255, 255, 255, 255, 255);
		push_pixel(0, 0, 0, 0, 0);
		push_pixel(128, 1, 254, 128, 127);
		push_pixel(1, 254, 1, 127, 128);
		wait_drained();

		// random rows over many settings
		for (seg = 0; seg < SEGMENTS; seg++) begin
			write_reg(CFG_MAX_DISPLACE, (seg == SEGMENTS - 1) ? $urandom_range(0, 255) : seg_disp[seg]);
			write_reg(CFG_ROW_WIDTH, seg_width[seg]);
			write_reg(CFG_SHIFT_MODE, seg % 2);
			write_reg(CFG_SOURCE_HAS_ALPHA, (seg / 2) % 2);
			src_idle_max = (seg % 4 == 1) ? 0 : 7;
			dst_idle_max = (seg % 3 == 2) ? 0 : 7;
			if (seg == 4)
				hold_wanted = 1'b1;
			for (k = 0; k < SEGMENT_ITEMS; k++) begin
				if ($urandom_range(0, 9) == 0)
					push_curve($urandom_range(0, 255), $urandom_range(0, 511));
				else
					push_pixel($urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
			end
			wait_drained();
		end

		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
